// ===== design/avccfg_pkg.sv =====
`default_nettype none

package avccfg_pkg;

    // one byte of the configuration record
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_record;
    } avccfg_in_t;

    // classified byte
    typedef struct packed {
        logic [4:0] byte_kind;
        logic [7:0] field_value;
        logic       record_done;
    } avccfg_out_t;

    // parse position within the record; the code equals the kind of the byte expected
    typedef enum logic [3:0] {
        PH_VERSION   = 4'd0,
        PH_PROFILE   = 4'd1,
        PH_COMPAT    = 4'd2,
        PH_LEVEL     = 4'd3,
        PH_LENSIZE   = 4'd4,
        PH_SPSCOUNT  = 4'd5,
        PH_SPSLEN_HI = 4'd6,
        PH_SPSLEN_LO = 4'd7,
        PH_SPSBYTE   = 4'd8,
        PH_PPSCOUNT  = 4'd9,
        PH_PPSLEN_HI = 4'd10,
        PH_PPSLEN_LO = 4'd11,
        PH_PPSBYTE   = 4'd12,
        PH_COMPLETE  = 4'd13
    } avccfg_phase_t;

    // result kinds beyond the phase codes
    localparam logic [4:0] KIND_IGNORED    = 5'd13;
    localparam logic [4:0] KIND_BADVERSION = 5'd14;
    localparam logic [4:0] KIND_BADLENSIZE = 5'd15;
    localparam logic [4:0] KIND_TRUNCATED  = 5'd16;

    // record format constants
    localparam logic [7:0] VERSION_ONE    = 8'h01;
    localparam logic [7:0] LENSIZE_MASK   = 8'h03;
    localparam logic [7:0] LENSIZE_FOUR   = 8'h03; // length size minus one
    localparam logic [7:0] SPSCOUNT_MASK  = 8'h1f;

endpackage

`default_nettype wire

// ===== design/avc_config_record_parser_core.sv =====
`default_nettype none

// AVC decoder configuration record parser: takes the record one byte per transaction on
// the s_ channel (end_of_record marks the last byte) and returns one tagged byte per input
// on the m_ channel: field kind, field value (masked for length size and SPS count) and a
// record_done flag. Only the first SPS and PPS are followed; a bad version or length size
// flags that byte and the rest of the record is ignored, and a record ending before the
// PPS is complete gives a truncated kind on its last byte. One byte per cycle is sustained
// while the result side is not stalled: an input register feeds combinational classification
// logic into the result register, so each byte is held in the input register and then in
// the result register, and the input register absorbs one byte while a result is stalled.
module avc_config_record_parser_core
    import avccfg_pkg::*;
(
    input  wire         aclk,
    input  wire         aresetn,
    input  wire         s_valid,
    output logic        s_ready,
    input  avccfg_in_t  s_data,
    output logic        m_valid,
    input  wire         m_ready,
    output avccfg_out_t m_data
);

    // pipeline registers
    logic          in_valid_reg;
    avccfg_in_t    in_data_reg;
    logic          out_valid_reg;
    avccfg_out_t   out_data_reg;
    logic          advance;

    // parser state
    avccfg_phase_t phase_reg, phase_next;
    logic [15:0]   bytes_left_reg, bytes_left_next;
    logic [7:0]    length_high_reg, length_high_next;
    logic          discarding_reg, discarding_next;

    // classification of the registered byte
    logic [4:0]    kind;
    logic [7:0]    value;
    logic          record_open;
    logic          version_bad;
    logic          lensize_bad;
    logic [15:0]   bytes_dec;
    logic [15:0]   length_full;
    logic [7:0]    b;

    // handshake
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;
    assign m_valid = out_valid_reg;
    assign m_data  = out_data_reg;

    assign b           = in_data_reg.data_byte;
    assign bytes_dec   = bytes_left_reg - 16'd1;
    assign length_full = {length_high_reg, b};
    assign version_bad = (b != VERSION_ONE);
    assign lensize_bad = ((b & LENSIZE_MASK) != LENSIZE_FOUR);

    // next parser state for one byte
    always_comb begin
        phase_next       = phase_reg;
        bytes_left_next  = bytes_left_reg;
        length_high_next = length_high_reg;
        discarding_next  = discarding_reg;

        if (!discarding_reg) begin
            unique case (phase_reg)
                PH_VERSION: begin
                    if (version_bad) begin
                        discarding_next = 1'b1;
                    end else begin
                        phase_next = PH_PROFILE;
                    end
                end
                PH_PROFILE:  phase_next = PH_COMPAT;
                PH_COMPAT:   phase_next = PH_LEVEL;
                PH_LEVEL:    phase_next = PH_LENSIZE;
                PH_LENSIZE: begin
                    if (lensize_bad) begin
                        discarding_next = 1'b1;
                    end else begin
                        phase_next = PH_SPSCOUNT;
                    end
                end
                PH_SPSCOUNT: phase_next = PH_SPSLEN_HI;
                PH_SPSLEN_HI: begin
                    length_high_next = b;
                    phase_next       = PH_SPSLEN_LO;
                end
                PH_SPSLEN_LO: begin
                    bytes_left_next = length_full;
                    phase_next      = (length_full == 16'd0) ? PH_PPSCOUNT : PH_SPSBYTE;
                end
                PH_SPSBYTE: begin
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 16'd0) begin
                        phase_next = PH_PPSCOUNT;
                    end
                end
                PH_PPSCOUNT: phase_next = PH_PPSLEN_HI;
                PH_PPSLEN_HI: begin
                    length_high_next = b;
                    phase_next       = PH_PPSLEN_LO;
                end
                PH_PPSLEN_LO: begin
                    bytes_left_next = length_full;
                    phase_next      = (length_full == 16'd0) ? PH_COMPLETE : PH_PPSBYTE;
                end
                PH_PPSBYTE: begin
                    bytes_left_next = bytes_dec;
                    if (bytes_dec == 16'd0) begin
                        phase_next = PH_COMPLETE;
                    end
                end
                default: phase_next = phase_reg;
            endcase
        end

        // record still short of a complete PPS after this byte
        record_open = !discarding_next && (phase_next < PH_COMPLETE);

        // end of record: rearm for the next record
        if (in_data_reg.end_of_record) begin
            phase_next       = PH_VERSION;
            bytes_left_next  = 16'd0;
            length_high_next = 8'd0;
            discarding_next  = 1'b0;
        end
    end

    // result for one byte
    always_comb begin
        kind  = {1'b0, phase_reg};
        value = b;

        if (discarding_reg) begin
            kind = KIND_IGNORED;
        end else begin
            unique case (phase_reg)
                PH_VERSION: begin
                    if (version_bad) begin
                        kind = KIND_BADVERSION;
                    end
                end
                PH_LENSIZE: begin
                    value = b & LENSIZE_MASK;
                    if (lensize_bad) begin
                        kind = KIND_BADLENSIZE;
                    end
                end
                PH_SPSCOUNT: value = b & SPSCOUNT_MASK;
                PH_COMPLETE: kind = KIND_IGNORED;
                default:     kind = {1'b0, phase_reg};
            endcase
        end

        // last byte of an unfinished record is flagged as truncated
        if (in_data_reg.end_of_record && record_open) begin
            kind  = KIND_TRUNCATED;
            value = b;
        end
    end

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
        if (s_ready && s_valid) begin
            in_data_reg <= s_data;
        end
    end

    // parser state, updated as each byte moves to the result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg       <= PH_VERSION;
            bytes_left_reg  <= 16'd0;
            length_high_reg <= 8'd0;
            discarding_reg  <= 1'b0;
        end else if (advance) begin
            phase_reg       <= phase_next;
            bytes_left_reg  <= bytes_left_next;
            length_high_reg <= length_high_next;
            discarding_reg  <= discarding_next;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
        if (advance) begin
            out_data_reg.byte_kind   <= kind;
            out_data_reg.field_value <= value;
            out_data_reg.record_done <= in_data_reg.end_of_record;
        end
    end

endmodule

`default_nettype wire

// ===== dv/tb.sv =====
`timescale 1ns / 100ps

module tb;
    import avccfg_pkg::*;

    localparam int SCORED_TARGET = 1400;
    localparam int CYCLE_LIMIT   = 400000;
    localparam int DIR_ROWS      = 28;
    localparam int LONG_HOLD     = 80;
    localparam int DRAIN_CYCLES  = 8;
    localparam logic [12:0] NO_TAG = '0;

    // one row of the directed table; has_tag marks a result typed in by hand
    typedef struct packed {
        logic [7:0] data_byte;
        logic       end_of_record;
        logic       has_tag;
        logic [4:0] byte_kind;
        logic [7:0] field_value;
    } stim_row_t;

    logic        aclk    = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    avccfg_in_t  s_data  = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    avccfg_out_t m_data;

    // parser state as predicted
    avccfg_phase_t rec_phase   = PH_VERSION;
    logic [15:0]   rec_left    = '0;
    logic [7:0]    rec_len_hi  = '0;
    logic          rec_discard = 1'b0;

    avccfg_out_t expected_tags[$];
    stim_row_t   dir_rows[DIR_ROWS];

    int cycle_count    = 0;
    int mismatch_count = 0;
    int results_seen   = 0;
    int bytes_sent     = 0;
    int scored_bytes   = 0;
    int records_sent   = 0;
    int send_run_left  = 0;
    int large_left     = 3;

    avc_config_record_parser_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #1 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results pending", cycle_count,
                     expected_tags.size());
            $display("FAIL");
            $finish;
        end
    end

    // idle draw shared by both sides, with occasional stretches of no idling
    function automatic int pick_idle(inout int run_left);
        if (run_left > 0) begin
            run_left--;
            return 0;
        end
        if ($urandom_range(0, 24) == 0)
            run_left = $urandom_range(15, 60);
        if ($urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(1, 12);
    endfunction

    // predicted tag for one byte, advancing the predicted parser state
    function automatic avccfg_out_t classify_byte(input avccfg_in_t item);
        avccfg_out_t tag;
        logic        err_now;
        logic [7:0]  b;
        b               = item.data_byte;
        err_now         = 1'b0;
        tag.field_value = b;
        tag.record_done = item.end_of_record;
        if (rec_discard) begin
            tag.byte_kind = KIND_IGNORED;
        end else begin
            tag.byte_kind = {1'b0, rec_phase};
            case (rec_phase)
                PH_VERSION: begin
                    if (b != VERSION_ONE) begin
                        tag.byte_kind = KIND_BADVERSION;
                        err_now       = 1'b1;
                        rec_discard   = 1'b1;
                    end else begin
                        rec_phase = PH_PROFILE;
                    end
                end
                PH_PROFILE, PH_COMPAT, PH_LEVEL: begin
                    rec_phase = avccfg_phase_t'(rec_phase + 4'd1);
                end
                PH_LENSIZE: begin
                    tag.field_value = b & LENSIZE_MASK;
                    if (tag.field_value != LENSIZE_FOUR) begin
                        tag.byte_kind = KIND_BADLENSIZE;
                        err_now       = 1'b1;
                        rec_discard   = 1'b1;
                    end else begin
                        rec_phase = PH_SPSCOUNT;
                    end
                end
                PH_SPSCOUNT: begin
                    tag.field_value = b & SPSCOUNT_MASK;
                    rec_phase       = PH_SPSLEN_HI;
                end
                PH_SPSLEN_HI, PH_PPSLEN_HI: begin
                    rec_len_hi = b;
                    rec_phase  = avccfg_phase_t'(rec_phase + 4'd1);
                end
                PH_SPSLEN_LO: begin
                    rec_left = {rec_len_hi, b};
                    if (rec_left == 16'd0)
                        rec_phase = PH_PPSCOUNT;
                    else
                        rec_phase = PH_SPSBYTE;
                end
                PH_PPSLEN_LO: begin
                    rec_left = {rec_len_hi, b};
                    if (rec_left == 16'd0)
                        rec_phase = PH_COMPLETE;
                    else
                        rec_phase = PH_PPSBYTE;
                end
                PH_SPSBYTE: begin
                    rec_left = rec_left - 16'd1;
                    if (rec_left == 16'd0)
                        rec_phase = PH_PPSCOUNT;
                end
                PH_PPSBYTE: begin
                    rec_left = rec_left - 16'd1;
                    if (rec_left == 16'd0)
                        rec_phase = PH_COMPLETE;
                end
                PH_PPSCOUNT: begin
                    rec_phase = PH_PPSLEN_HI;
                end
                default: begin
                    tag.byte_kind = KIND_IGNORED;
                end
            endcase
        end
        // last byte closes the record; an unfinished record is truncated
        if (item.end_of_record) begin
            if (!rec_discard && !err_now && rec_phase < PH_COMPLETE)
                tag.byte_kind = KIND_TRUNCATED;
            if (tag.byte_kind == KIND_TRUNCATED)
                tag.field_value = b;
            rec_phase   = PH_VERSION;
            rec_left    = '0;
            rec_len_hi  = '0;
            rec_discard = 1'b0;
        end
        return tag;
    endfunction

    // offer one byte, and on acceptance queue its expected tag
    task automatic deliver_byte(input avccfg_in_t item, input logic use_tag,
                                input avccfg_out_t hand_tag);
        int          gap;
        avccfg_out_t tag;
        gap = pick_idle(send_run_left);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        tag = classify_byte(item);
        expected_tags.push_back(use_tag ? hand_tag : tag);
        bytes_sent++;
        if (tag.byte_kind != KIND_IGNORED)
            scored_bytes++;
    endtask

    // payload length: mostly short, a few medium, very rarely over 255
    function automatic logic [15:0] draw_nal_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 16'd0;
        if (r < 88)
            return 16'($urandom_range(1, 8));
        if (r < 98 || large_left == 0)
            return 16'($urandom_range(9, 40));
        large_left--;
        return 16'($urandom_range(256, 270));
    endfunction

    // one random record: mostly well formed, some cut short, some broken, some noise
    task automatic send_record();
        logic [7:0]  rec_q[$];
        logic [15:0] nal_len;
        int          shape;
        int          cut;
        avccfg_in_t  item;
        shape = $urandom_range(0, 99);
        rec_q.push_back(VERSION_ONE);
        repeat (3) rec_q.push_back(8'($urandom()));
        rec_q.push_back((8'($urandom()) & ~LENSIZE_MASK) | LENSIZE_FOUR);
        rec_q.push_back(8'($urandom()));
        nal_len = draw_nal_len();
        rec_q.push_back(nal_len[15:8]);
        rec_q.push_back(nal_len[7:0]);
        repeat (nal_len) rec_q.push_back(8'($urandom()));
        rec_q.push_back(8'($urandom()));
        nal_len = draw_nal_len();
        rec_q.push_back(nal_len[15:8]);
        rec_q.push_back(nal_len[7:0]);
        repeat (nal_len) rec_q.push_back(8'($urandom()));
        repeat ($urandom_range(0, 3)) rec_q.push_back(8'($urandom()));

        if (shape >= 85 && shape < 92) begin
            rec_q[4] = (rec_q[4] & ~LENSIZE_MASK) | 8'($urandom_range(0, 2));
        end else if (shape >= 92) begin
            rec_q.delete();
            repeat ($urandom_range(1, 8)) rec_q.push_back(8'($urandom()));
            if (shape >= 96)
                rec_q[0] = VERSION_ONE;
        end
        if (shape >= 70 && shape < 92) begin
            cut = $urandom_range(1, rec_q.size() - 1);
            while (rec_q.size() > cut) void'(rec_q.pop_back());
        end

        foreach (rec_q[i]) begin
            item.data_byte     = rec_q[i];
            item.end_of_record = (i == rec_q.size() - 1);
            deliver_byte(item, 1'b0, '0);
        end
        records_sent++;
    endtask

    task automatic report_mismatch(input string field, input logic [7:0] got,
                                   input logic [7:0] want);
        if (mismatch_count < 40)
            $display("mismatch on result %0d: %s got %h expected %h", results_seen, field,
                     got, want);
        mismatch_count++;
    endtask

    // result checking against the oldest expectation
    always @(posedge aclk) begin : result_check
        avccfg_out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (expected_tags.size() == 0) begin
                report_mismatch("unexpected transaction", {3'b000, m_data.byte_kind}, '0);
            end else begin
                want = expected_tags.pop_front();
                if (m_data.byte_kind !== want.byte_kind)
                    report_mismatch("byte_kind", {3'b000, m_data.byte_kind},
                                    {3'b000, want.byte_kind});
                if (m_data.field_value !== want.field_value)
                    report_mismatch("field_value", m_data.field_value, want.field_value);
                if (m_data.record_done !== want.record_done)
                    report_mismatch("record_done", {7'd0, m_data.record_done},
                                    {7'd0, want.record_done});
            end
            results_seen <= results_seen + 1;
        end
    end

    // result side: random stalls, plus two long hold-offs to back the block up
    initial begin : result_sink
        int idle;
        int taken;
        int run_left;
        taken    = 0;
        run_left = 0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (taken == 300 || taken == 1000)
                idle = LONG_HOLD;
            else
                idle = pick_idle(run_left);
            if (idle > 0) begin
                m_ready <= 1'b0;
                repeat (idle) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            taken++;
        end
    end

    // stimulus
    initial begin : stimulus
        avccfg_in_t  item;
        avccfg_out_t hand_tag;
        logic        paused;
        paused = 1'b0;

        dir_rows = '{
            // full record: zero pps length, then a trailing byte
            {8'h01, 1'b0, 1'b1, {1'b0, PH_VERSION}, 8'h01},
            {8'hff, 1'b0, 1'b0, NO_TAG},
            {8'h00, 1'b0, 1'b0, NO_TAG},
            {8'h80, 1'b0, 1'b0, NO_TAG},
            {8'hff, 1'b0, 1'b0, NO_TAG},
            {8'hff, 1'b0, 1'b1, {1'b0, PH_SPSCOUNT}, 8'h1f},
            {8'h00, 1'b0, 1'b0, NO_TAG},
            {8'h01, 1'b0, 1'b0, NO_TAG},
            {8'haa, 1'b0, 1'b0, NO_TAG},
            {8'hff, 1'b0, 1'b1, {1'b0, PH_PPSCOUNT}, 8'hff},
            {8'h00, 1'b0, 1'b0, NO_TAG},
            {8'h00, 1'b0, 1'b0, NO_TAG},
            {8'h55, 1'b1, 1'b1, KIND_IGNORED, 8'h55},
            // bad version on the final byte
            {8'h00, 1'b1, 1'b1, KIND_BADVERSION, 8'h00},
            // bad length size, then a byte that is ignored
            {8'h01, 1'b0, 1'b1, {1'b0, PH_VERSION}, 8'h01},
            {8'h00, 1'b0, 1'b0, NO_TAG},
            {8'h00, 1'b0, 1'b0, NO_TAG},
            {8'h00, 1'b0, 1'b0, NO_TAG},
            {8'hfc, 1'b0, 1'b1, KIND_BADLENSIZE, 8'h00},
            {8'hff, 1'b1, 1'b1, KIND_IGNORED, 8'hff},
            // zero sps length, record ends at the pps count
            {8'h01, 1'b0, 1'b1, {1'b0, PH_VERSION}, 8'h01},
            {8'hff, 1'b0, 1'b0, NO_TAG},
            {8'hff, 1'b0, 1'b0, NO_TAG},
            {8'hff, 1'b0, 1'b0, NO_TAG},
            {8'h07, 1'b0, 1'b0, NO_TAG},
            {8'he0, 1'b0, 1'b0, NO_TAG},
            {8'h00, 1'b0, 1'b0, NO_TAG},
            {8'h00, 1'b1, 1'b1, KIND_TRUNCATED, 8'h00}
        };

        // synchronous reset
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (int r = 0; r < DIR_ROWS; r++) begin
            item.data_byte        = dir_rows[r].data_byte;
            item.end_of_record    = dir_rows[r].end_of_record;
            hand_tag.byte_kind    = dir_rows[r].byte_kind;
            hand_tag.field_value  = dir_rows[r].field_value;
            hand_tag.record_done  = dir_rows[r].end_of_record;
            deliver_byte(item, dir_rows[r].has_tag, hand_tag);
        end
        records_sent = 4;

        // random records, with one pause until everything has drained
        while (scored_bytes < SCORED_TARGET) begin
            send_record();
            if (!paused && scored_bytes >= SCORED_TARGET / 2) begin
                paused = 1'b1;
                s_valid <= 1'b0;
                while (expected_tags.size() != 0) @(posedge aclk);
            end
        end
        s_valid <= 1'b0;

        // drain
        while (expected_tags.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("covered %0d input transactions in %0d records, %0d results compared",
                 bytes_sent, records_sent, results_seen);
        $display("mismatches: %0d", mismatch_count);
        if (mismatch_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
